>>> hw/rtl/sra_pkg.sv
// shared types and constants of the skyline rectangle allocator
`timescale 1ns / 1ps
package sra_pkg;

  localparam int REQ_BITS  = 12;
  localparam int AREA_BITS = 25;
  localparam int REG_BITS  = 13;

  localparam logic [AREA_BITS-1:0] AREA_MAX = {AREA_BITS{1'b1}};
  localparam logic [REG_BITS-1:0]  DIM_RESET = REG_BITS'(512);

  localparam logic ACT_ALLOC = 1'b0;
  localparam logic ACT_CLEAR = 1'b1;

  localparam logic REG_ATLAS_WIDTH  = 1'b0;
  localparam logic REG_ATLAS_HEIGHT = 1'b1;

  typedef struct packed {
    logic                action;
    logic [REQ_BITS-1:0] req_width;
    logic [REQ_BITS-1:0] req_height;
  } sra_in_t;

  typedef struct packed {
    logic                 placed;
    logic [REQ_BITS-1:0]  origin_x;
    logic [REQ_BITS-1:0]  origin_y;
    logic [AREA_BITS-1:0] used_area;
  } sra_out_t;

  typedef enum logic [3:0] {
    ST_INIT,
    ST_IDLE,
    ST_CLEAR,
    ST_SC_RD,
    ST_SC_EV,
    ST_RB_RD,
    ST_RB_EV,
    ST_RB_FIN,
    ST_RESP
  } sra_state_e;

endpackage

>>> hw/rtl/sra_ram.sv
// generic single write port ram with registered read
`timescale 1ns / 1ps
module sra_ram #(
  parameter int WIDTH = 37,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> hw/rtl/skyline_rect_allocator_core.sv
// skyline rectangle allocator top level: sequencer, fit search and table rebuild
//
//  channel | signals                              | direction
//  in      | in_valid_i, in_stall_o, in_data_i    | request transaction in
//  out     | out_valid_o, out_stall_i, out_data_o | result transaction out
//  cfg     | cfg_we_i, cfg_idx_i, cfg_data_i      | register write
//
// one request at a time; an allocate reads the segments visited by the fit walks
// (one walk per start segment), then reads each old segment and adds the new one in
// the rebuild pass, closes the table and posts the result; a refused request skips
// the rebuild, a zero width request posts its result at once, a clear after one write.
// after reset the initial segment is written before the first request.
// a waiting result holds the sequencer in its final state until taken.
`timescale 1ns / 1ps
module skyline_rect_allocator_core
  import sra_pkg::*;
#(
  parameter int MAX_SEGMENTS = 64,
  parameter int COORD_BITS   = 12
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  sra_in_t             in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output sra_out_t            out_data_o,
  input  logic                cfg_we_i,
  input  logic                cfg_idx_i,
  input  logic [REG_BITS-1:0] cfg_data_i
);

  localparam int C  = COORD_BITS;
  localparam int WW = 3 * C + 1;
  localparam int AW = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
  localparam int CW = $clog2(MAX_SEGMENTS + 1);
  localparam int SW = ((C > REQ_BITS) ? C : REQ_BITS) + 2;
  localparam int PW = 2 * REQ_BITS;
  localparam logic [SW-1:0] DIM_TOP = SW'(1) << C;
  localparam logic [SW-1:0] DIM_MIN = SW'(3);
  localparam logic [CW-1:0] CNT_MAX = CW'(MAX_SEGMENTS);

  sra_state_e state_q, state_d;

  logic [REG_BITS-1:0]  cfg_w_q, cfg_h_q;
  logic                 bank_q, bank_d;
  logic [CW-1:0]        cnt_q, cnt_d;
  logic [AREA_BITS-1:0] area_q, area_d;
  logic [REQ_BITS-1:0]  rw_q, rw_d, rh_q, rh_d;
  logic [PW-1:0]        prod_q, prod_d;
  logic [CW-1:0]        i_q, i_d, j_q, j_d, k_q, k_d, wr_q, wr_d;
  logic [C-1:0]         y_q, y_d, xi_q, xi_d;
  logic [C:0]           wi_q, wi_d;
  logic [SW-1:0]        s_q, s_d;
  logic                 found_q, found_d;
  logic [AW-1:0]        best_q, best_d;
  logic [SW-1:0]        bbot_q, bbot_d;
  logic [C:0]           bw_q, bw_d;
  logic [C-1:0]         by_q, by_d, bx_q, bx_d;
  logic                 newd_q, newd_d, trim_q, trim_d, pv_q, pv_d;
  logic [SW-1:0]        pe_q, pe_d;
  logic [C-1:0]         px_q, px_d, py_q, py_d;
  logic [C:0]           pw_q, pw_d;
  sra_out_t             res_q, res_d, out_q, out_d;
  logic                 ov_q, ov_d;

  // effective atlas limits
  logic [SW-1:0] effw, effh, wlim, hlim;
  always_comb begin
    effw = SW'(cfg_w_q);
    effh = SW'(cfg_h_q);
    if (effw < DIM_MIN) effw = DIM_MIN;
    else if (effw > DIM_TOP) effw = DIM_TOP;
    if (effh < DIM_MIN) effh = DIM_MIN;
    else if (effh > DIM_TOP) effh = DIM_TOP;
    wlim = effw - SW'(1);
    hlim = effh - SW'(1);
  end

  // segment tables, ping-pong
  logic          we;
  logic          wbank;
  logic [AW-1:0] waddr, raddr;
  logic [WW-1:0] wdata, rd0, rd1, rd;
  logic [C-1:0]  sx, sy;
  logic [C:0]    sw;

  sra_ram #(.WIDTH(WW), .DEPTH(MAX_SEGMENTS)) u_ram0 (
    .clk_i  (clk_i),
    .we_i   (we && !wbank),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .raddr_i(raddr),
    .rdata_o(rd0)
  );

  sra_ram #(.WIDTH(WW), .DEPTH(MAX_SEGMENTS)) u_ram1 (
    .clk_i  (clk_i),
    .we_i   (we && wbank),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .raddr_i(raddr),
    .rdata_o(rd1)
  );

  assign rd = bank_q ? rd1 : rd0;
  assign sx = rd[3*C:2*C+1];
  assign sy = rd[2*C:C+1];
  assign sw = rd[C:0];
  assign raddr = (state_q == ST_RB_RD || state_q == ST_RB_EV) ? k_q[AW-1:0] : j_q[AW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_w_q <= DIM_RESET;
      cfg_h_q <= DIM_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_ATLAS_WIDTH:  cfg_w_q <= cfg_data_i;
        REG_ATLAS_HEIGHT: cfg_h_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_INIT;
      bank_q  <= 1'b0;
      cnt_q   <= CW'(1);
      area_q  <= '0;
      ov_q    <= 1'b0;
      found_q <= 1'b0;
      newd_q  <= 1'b0;
      trim_q  <= 1'b0;
      pv_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      bank_q  <= bank_d;
      cnt_q   <= cnt_d;
      area_q  <= area_d;
      ov_q    <= ov_d;
      found_q <= found_d;
      newd_q  <= newd_d;
      trim_q  <= trim_d;
      pv_q    <= pv_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rw_q   <= rw_d;
    rh_q   <= rh_d;
    prod_q <= prod_d;
    i_q    <= i_d;
    j_q    <= j_d;
    k_q    <= k_d;
    wr_q   <= wr_d;
    y_q    <= y_d;
    xi_q   <= xi_d;
    wi_q   <= wi_d;
    s_q    <= s_d;
    best_q <= best_d;
    bbot_q <= bbot_d;
    bw_q   <= bw_d;
    by_q   <= by_d;
    bx_q   <= bx_d;
    pe_q   <= pe_d;
    px_q   <= px_d;
    py_q   <= py_d;
    pw_q   <= pw_d;
    res_q  <= res_d;
    out_q  <= out_d;
  end

  logic                 first, fail, ok, better, emit;
  logic [C-1:0]         yn, ex, ey;
  logic [C:0]           ew;
  logic [SW-1:0]        sn, bot, shrink;
  logic [CW-1:0]        ni, nj, nk;
  logic [AREA_BITS:0]   asum;
  logic [SW-1:0]        ox_ext, oy_ext;

  always_comb begin
    state_d = state_q;
    bank_d  = bank_q;
    cnt_d   = cnt_q;
    area_d  = area_q;
    rw_d    = rw_q;
    rh_d    = rh_q;
    prod_d  = prod_q;
    i_d     = i_q;
    j_d     = j_q;
    k_d     = k_q;
    wr_d    = wr_q;
    y_d     = y_q;
    xi_d    = xi_q;
    wi_d    = wi_q;
    s_d     = s_q;
    found_d = found_q;
    best_d  = best_q;
    bbot_d  = bbot_q;
    bw_d    = bw_q;
    by_d    = by_q;
    bx_d    = bx_q;
    newd_d  = newd_q;
    trim_d  = trim_q;
    pv_d    = pv_q;
    pe_d    = pe_q;
    px_d    = px_q;
    py_d    = py_q;
    pw_d    = pw_q;
    res_d   = res_q;
    out_d   = out_q;
    ov_d    = ov_q;
    we      = 1'b0;
    wbank   = bank_q;
    waddr   = '0;
    wdata   = {C'(1), C'(1), (C+1)'(effw - SW'(2))};
    in_stall_o = (state_q != ST_IDLE);

    first  = (j_q == i_q);
    fail   = 1'b0;
    ok     = 1'b0;
    better = 1'b0;
    emit   = 1'b0;
    yn     = (first || sy > y_q) ? sy : y_q;
    sn     = (first ? '0 : s_q) + SW'(sw);
    bot    = SW'(yn) + SW'(rh_q);
    ni     = i_q + CW'(1);
    nj     = j_q + CW'(1);
    nk     = k_q + CW'(1);
    ex     = sx;
    ey     = sy;
    ew     = sw;
    shrink = pe_q - SW'(sx);
    asum   = (AREA_BITS+1)'(area_q) + (AREA_BITS+1)'(prod_q);
    ox_ext = SW'(bx_q);
    oy_ext = SW'(by_q);

    if (ov_q && !out_stall_i) ov_d = 1'b0;

    unique case (state_q)
      ST_INIT: begin
        we      = 1'b1;
        state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid_i) begin
          rw_d   = in_data_i.req_width;
          rh_d   = in_data_i.req_height;
          prod_d = PW'(in_data_i.req_width) * PW'(in_data_i.req_height);
          i_d    = '0;
          j_d    = '0;
          found_d = 1'b0;
          if (in_data_i.action == ACT_CLEAR) begin
            state_d = ST_CLEAR;
          end else if (in_data_i.req_width == '0) begin
            res_d   = '{placed: 1'b0, origin_x: '0, origin_y: '0, used_area: area_q};
            state_d = ST_RESP;
          end else begin
            state_d = ST_SC_RD;
          end
        end
      end
      ST_CLEAR: begin
        we      = 1'b1;
        cnt_d   = CW'(1);
        area_d  = '0;
        res_d   = '{placed: 1'b1, origin_x: '0, origin_y: '0, used_area: '0};
        state_d = ST_RESP;
      end
      ST_SC_RD: begin
        state_d = ST_SC_EV;
      end
      ST_SC_EV: begin
        if (first) begin
          xi_d = sx;
          wi_d = sw;
          if (SW'(sx) + SW'(rw_q) > wlim) fail = 1'b1;
        end
        if (bot > hlim) fail = 1'b1;
        if (!fail && sn >= SW'(rw_q)) ok = 1'b1;
        if (!fail && !ok && nj >= cnt_q) fail = 1'b1;
        if (fail || ok) begin
          if (ok) begin
            better = !found_q || bot < bbot_q ||
                     (bot == bbot_q && (first ? sw : wi_q) < bw_q);
          end
          if (better) begin
            found_d = 1'b1;
            best_d  = i_q[AW-1:0];
            bbot_d  = bot;
            bw_d    = first ? sw : wi_q;
            by_d    = yn;
            bx_d    = first ? sx : xi_q;
          end
          if (ni >= cnt_q) begin
            if (!(found_q || better) || cnt_q >= CNT_MAX) begin
              res_d   = '{placed: 1'b0, origin_x: '0, origin_y: '0, used_area: area_q};
              state_d = ST_RESP;
            end else begin
              k_d     = '0;
              wr_d    = '0;
              newd_d  = 1'b0;
              trim_d  = 1'b0;
              pv_d    = 1'b0;
              state_d = ST_RB_RD;
            end
          end else begin
            i_d     = ni;
            j_d     = ni;
            state_d = ST_SC_RD;
          end
        end else begin
          j_d     = nj;
          y_d     = yn;
          s_d     = sn;
          state_d = ST_SC_RD;
        end
      end
      ST_RB_RD: begin
        state_d = ST_RB_EV;
      end
      ST_RB_EV: begin
        if (k_q[AW-1:0] == best_q && !newd_q) begin
          // new segment goes in ahead of the one it lands on
          ex      = bx_q;
          ey      = C'(SW'(by_q) + SW'(rh_q));
          ew      = (C+1)'(rw_q);
          emit    = 1'b1;
          newd_d  = 1'b1;
          trim_d  = 1'b1;
          pe_d    = SW'(bx_q) + SW'(rw_q);
          state_d = ST_RB_RD;
        end else begin
          emit = 1'b1;
          if (trim_q) begin
            if (SW'(sx) < pe_q) begin
              if (SW'(sw) <= shrink) begin
                emit = 1'b0;
              end else begin
                ex     = C'(SW'(sx) + shrink);
                ew     = (C+1)'(SW'(sw) - shrink);
                trim_d = 1'b0;
              end
            end else begin
              trim_d = 1'b0;
            end
          end
          k_d     = nk;
          state_d = (nk >= cnt_q) ? ST_RB_FIN : ST_RB_RD;
        end
        if (emit) begin
          if (!pv_q) begin
            pv_d = 1'b1;
            px_d = ex;
            py_d = ey;
            pw_d = ew;
          end else if (py_q == ey) begin
            pw_d = pw_q + ew;
          end else begin
            we    = 1'b1;
            wbank = !bank_q;
            waddr = wr_q[AW-1:0];
            wdata = {px_q, py_q, pw_q};
            wr_d  = wr_q + CW'(1);
            px_d  = ex;
            py_d  = ey;
            pw_d  = ew;
          end
        end
      end
      ST_RB_FIN: begin
        we     = 1'b1;
        wbank  = !bank_q;
        waddr  = wr_q[AW-1:0];
        wdata  = {px_q, py_q, pw_q};
        cnt_d  = wr_q + CW'(1);
        bank_d = !bank_q;
        area_d = (asum > (AREA_BITS+1)'(AREA_MAX)) ? AREA_MAX : asum[AREA_BITS-1:0];
        res_d  = '{placed: 1'b1, origin_x: ox_ext[REQ_BITS-1:0],
                   origin_y: oy_ext[REQ_BITS-1:0], used_area: area_d};
        state_d = ST_RESP;
      end
      ST_RESP: begin
        if (!ov_q || !out_stall_i) begin
          out_d   = res_q;
          ov_d    = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign out_valid_o = ov_q;
  assign out_data_o  = out_q;

endmodule
